// File: rtl/oehf_pkg.sv
// Shared types and codes for the occupancy enclosure and hole-fill block.
// No dependencies.
package oehf_pkg;

    localparam int ROW_W  = 7;
    localparam int COL_W  = 9;
    localparam int VAL_W  = 16;
    localparam int CELL_W = VAL_W + 1;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    localparam logic [1:0] ST_OUTSIDE = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_OUTSIDE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] relief;
    } cmd_t;

    typedef struct packed {
        logic [7:0] nrows;
        logic [9:0] ncols;
        logic [3:0] nlev;
    } cfg_t;

endpackage

// File: rtl/oehf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oehf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/oehf_front.sv
// Front end: accepts input beats, classifies them and queues commands.
// Depends on oehf_pkg.
module oehf_front import oehf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    clr_busy,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_func,
    input  logic [ROW_W-1:0]        s_row,
    input  logic [COL_W-1:0]        s_col,
    input  logic signed [VAL_W-1:0] s_relief,
    output logic                    q_valid,
    output cmd_t                    q_cmd,
    input  logic                    q_pop
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_in;
    logic       keep, in_grid, push;

    assign in_grid = ({1'b0, s_row} < cfg.nrows) && ({1'b0, s_col} < cfg.ncols);

    always_comb begin
        cmd_in.row    = s_row;
        cmd_in.col    = s_col;
        cmd_in.relief = s_relief;
        cmd_in.op     = OP_INSERT;
        keep          = 1'b0;
        unique case (s_func)
            FN_INSERT: begin
                cmd_in.op = OP_INSERT;
                keep      = in_grid;
            end
            FN_QUERY: begin
                cmd_in.op = in_grid ? OP_QUERY : OP_OUTSIDE;
                keep      = 1'b1;
            end
            FN_CLEAR: begin
                cmd_in.op = OP_CLEAR;
                keep      = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2) && !clr_busy;
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("command queue overfilled");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> cnt_reg != 2'd0)
        else $error("pop from empty command queue");

endmodule

// File: rtl/oehf_back.sv
// Back end: runs inserts, clears and queries against the cell RAM, holds the result.
// Depends on oehf_pkg and oehf_ram.
module oehf_back import oehf_pkg::*; #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 512
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    q_valid,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output logic                    clr_busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [VAL_W-1:0] m_fill_relief,
    output logic [2:0]              m_level
);

    localparam int AW_R  = $clog2(GRID_ROWS);
    localparam int AW_C  = $clog2(GRID_COLS);
    localparam int AW    = AW_R + AW_C;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [8:0] {
        S_CLR      = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_INS_RD   = 9'b000000100,
        S_INS_WR   = 9'b000001000,
        S_ENC_RD   = 9'b000010000,
        S_ENC_EV   = 9'b000100000,
        S_BLK_INIT = 9'b001000000,
        S_BLK_RD   = 9'b010000000,
        S_BLK_EV   = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [7:0]              kr_reg, kr_next;
    logic                    above_reg, above_next;
    logic                    below_reg, below_next;
    logic                    self_occ_reg, self_occ_next;
    logic signed [VAL_W-1:0] self_val_reg, self_val_next;
    logic [2:0]              lvl_reg, lvl_next;
    logic [7:0]              br_reg, br_next;
    logic [9:0]              bc_reg, bc_next;
    logic                    found_reg, found_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_relief_reg, m_relief_next;
    logic [2:0]              m_level_reg, m_level_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [CELL_W-1:0]       ram_wdata, ram_rdata;
    logic [7:0]              rd_r;
    logic [9:0]              rd_c;
    logic                    occ;
    logic signed [VAL_W-1:0] val;
    logic                    load;
    logic                    ab, bl, so_n;
    logic signed [VAL_W-1:0] sv_n;
    logic                    fn;
    logic signed [VAL_W-1:0] bn;
    logic [7:0]              size, r0, rend;
    logic [8:0]              rsum;
    logic [9:0]              c0, cend;
    logic [10:0]             csum;

    oehf_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign occ       = ram_rdata[CELL_W-1];
    assign val       = ram_rdata[VAL_W-1:0];
    assign ram_raddr = {AW_R'(rd_r), AW_C'(rd_c)};

    assign size = 8'd1 << lvl_reg;
    assign r0   = {1'b0, cmd_reg.row} & ~(size - 8'd1);
    assign rsum = {1'b0, r0} + {1'b0, size};
    assign rend = (rsum > {1'b0, cfg.nrows}) ? cfg.nrows : rsum[7:0];
    assign c0   = {1'b0, cmd_reg.col} & ~({2'b0, size} - 10'd1);
    assign csum = {1'b0, c0} + {3'b0, size};
    assign cend = (csum > {1'b0, cfg.ncols}) ? cfg.ncols : csum[9:0];

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        clr_next      = clr_reg;
        kr_next       = kr_reg;
        above_next    = above_reg;
        below_next    = below_reg;
        self_occ_next = self_occ_reg;
        self_val_next = self_val_reg;
        lvl_next      = lvl_reg;
        br_next       = br_reg;
        bc_next       = bc_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_relief_next = m_relief_reg;
        m_level_next  = m_level_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_reg;
        ram_wdata     = '0;
        rd_r          = {1'b0, cmd_reg.row};
        rd_c          = {1'b0, cmd_reg.col};
        ab            = above_reg;
        bl            = below_reg;
        so_n          = self_occ_reg;
        sv_n          = self_val_reg;
        fn            = found_reg;
        bn            = best_reg;

        unique case (state_reg)
            S_CLR: begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid && !m_valid_reg) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.op)
                        OP_INSERT: state_next = S_INS_RD;
                        OP_QUERY: begin
                            kr_next       = '0;
                            above_next    = 1'b0;
                            below_next    = 1'b0;
                            self_occ_next = 1'b0;
                            state_next    = S_ENC_RD;
                        end
                        OP_CLEAR: begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_OUTSIDE: begin
                            load          = 1'b1;
                            m_status_next = ST_OUTSIDE;
                            m_relief_next = '0;
                            m_level_next  = '0;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {AW_R'(cmd_reg.row), AW_C'(cmd_reg.col)};
                ram_wdata = {1'b1, (!occ || cmd_reg.relief > val) ? cmd_reg.relief : val};
                state_next = S_IDLE;
            end
            S_ENC_RD: begin
                rd_r       = kr_reg;
                state_next = S_ENC_EV;
            end
            S_ENC_EV: begin
                ab = above_reg || (occ && kr_reg <= {1'b0, cmd_reg.row});
                bl = below_reg || (occ && kr_reg >= {1'b0, cmd_reg.row});
                if (kr_reg == {1'b0, cmd_reg.row}) begin
                    so_n = occ;
                    sv_n = val;
                end
                above_next    = ab;
                below_next    = bl;
                self_occ_next = so_n;
                self_val_next = sv_n;
                if ({1'b0, kr_reg} + 9'd1 == {1'b0, cfg.nrows}) begin
                    if (!(ab && bl)) begin
                        load          = 1'b1;
                        m_status_next = ST_OUTSIDE;
                        m_relief_next = '0;
                        m_level_next  = '0;
                    end else if (so_n) begin
                        load          = 1'b1;
                        m_status_next = ST_FOUND;
                        m_relief_next = sv_n;
                        m_level_next  = '0;
                    end else if (cfg.nlev <= 4'd1) begin
                        load          = 1'b1;
                        m_status_next = ST_NODATA;
                        m_relief_next = '0;
                        m_level_next  = '0;
                    end else begin
                        lvl_next   = 3'd1;
                        state_next = S_BLK_INIT;
                    end
                end else begin
                    kr_next    = kr_reg + 8'd1;
                    state_next = S_ENC_RD;
                end
            end
            S_BLK_INIT: begin
                br_next    = r0;
                bc_next    = c0;
                found_next = 1'b0;
                state_next = S_BLK_RD;
            end
            S_BLK_RD: begin
                rd_r       = br_reg;
                rd_c       = bc_reg;
                state_next = S_BLK_EV;
            end
            S_BLK_EV: begin
                fn = found_reg || occ;
                bn = (occ && (!found_reg || val > best_reg)) ? val : best_reg;
                found_next = fn;
                best_next  = bn;
                if ({1'b0, bc_reg} + 11'd1 < {1'b0, cend}) begin
                    bc_next    = bc_reg + 10'd1;
                    state_next = S_BLK_RD;
                end else if ({1'b0, br_reg} + 9'd1 < {1'b0, rend}) begin
                    br_next    = br_reg + 8'd1;
                    bc_next    = c0;
                    state_next = S_BLK_RD;
                end else if (fn) begin
                    load          = 1'b1;
                    m_status_next = ST_FOUND;
                    m_relief_next = bn;
                    m_level_next  = lvl_reg;
                end else if ({1'b0, lvl_reg} + 4'd1 < cfg.nlev) begin
                    lvl_next   = lvl_reg + 3'd1;
                    state_next = S_BLK_INIT;
                end else begin
                    load          = 1'b1;
                    m_status_next = ST_NODATA;
                    m_relief_next = '0;
                    m_level_next  = '0;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (load) begin
            m_valid_next = 1'b1;
            state_next   = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        kr_reg       <= kr_next;
        above_reg    <= above_next;
        below_reg    <= below_next;
        self_occ_reg <= self_occ_next;
        self_val_reg <= self_val_next;
        lvl_reg      <= lvl_next;
        br_reg       <= br_next;
        bc_reg       <= bc_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        m_status_reg <= m_status_next;
        m_relief_reg <= m_relief_next;
        m_level_reg  <= m_level_next;
    end

    assign clr_busy      = (state_reg == S_CLR);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_fill_relief = m_relief_reg;
    assign m_level       = m_level_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !m_valid_reg)
        else $error("result loaded over a pending beat");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_FOUND) |-> (m_relief_reg == '0 && m_level_reg == '0))
        else $error("non-found result carries data");

    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BLK_RD || state_reg == S_BLK_EV)
            |-> (lvl_reg != 3'd0 && {1'b0, lvl_reg} < cfg.nlev))
        else $error("block search level out of range");

endmodule

// File: rtl/occupancy_enclosure_and_hole_fill.sv
// Occupancy grid with column enclosure test and multi-level hole fill.
// An insert reads its cell and then writes it back in the back end. A query outside
// the grid in use is answered from the idle state; otherwise it reads and evaluates
// each row in use to scan its column, then, for an empty enclosed cell, each cell
// (clipped to the grid in use) of each aligned 2^k block tried. A clear, like the pass
// after reset, sweeps the cell RAM one entry per cycle over
// 2^(clog2(GRID_ROWS)+clog2(GRID_COLS)) entries (65536 by default); no input beat
// is taken during either sweep. The single read port of the cell RAM sets the pace.
// A pending result holds the back end until it is taken. A two-entry command queue
// separates acceptance from execution.
// Depends on oehf_pkg, oehf_front, oehf_back and oehf_ram.
module occupancy_enclosure_and_hole_fill import oehf_pkg::*; #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 512
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [9:0]              cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_func,
    input  logic [ROW_W-1:0]        s_row,
    input  logic [COL_W-1:0]        s_col,
    input  logic signed [VAL_W-1:0] s_relief,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [VAL_W-1:0] m_fill_relief,
    output logic [2:0]              m_level
);

    logic [7:0] rows_reg;
    logic [9:0] cols_reg;
    logic [3:0] lev_reg;
    cfg_t       cfg;
    logic       clr_busy, q_valid, q_pop;
    cmd_t       q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 8'd128;
            cols_reg <= 10'd512;
            lev_reg  <= 4'd5;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROWS:   rows_reg <= cfg_data[7:0];
                REG_COLS:   cols_reg <= cfg_data;
                REG_LEVELS: lev_reg  <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        cfg.nrows = (rows_reg == 8'd0) ? 8'd1 :
                    ((32'(rows_reg) > GRID_ROWS) ? 8'(GRID_ROWS) : rows_reg);
        cfg.ncols = (cols_reg == 10'd0) ? 10'd1 :
                    ((32'(cols_reg) > GRID_COLS) ? 10'(GRID_COLS) : cols_reg);
        cfg.nlev  = (lev_reg == 4'd0) ? 4'd1 : ((lev_reg > 4'd8) ? 4'd8 : lev_reg);
    end

    oehf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .clr_busy (clr_busy),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_row    (s_row),
        .s_col    (s_col),
        .s_relief (s_relief),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    oehf_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .clr_busy      (clr_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_fill_relief (m_fill_relief),
        .m_level       (m_level)
    );

endmodule
